// ===== rtl/core/ctcgsd_pkg.sv =====
package ctcgsd_pkg;

    // register indexes on the configuration port
    localparam int unsigned REG_VOCAB_SIZE = 0;
    localparam int unsigned REG_BLANK_ID   = 1;

    localparam int unsigned VOCAB_RESET = 1025;
    localparam int unsigned BLANK_RESET = 1024;

    // frame record index is wide enough for any vocabulary up to 65536 entries
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic signed [15:0] score;
        logic               end_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic        [11:0] token_id;
        logic        [15:0] start_frame;
        logic        [15:0] stop_frame;
        logic signed [15:0] span_score;
        logic               has_token;
        logic               sequence_done;
        logic               last;
    } t_out_item;

    // one finished frame, handed from the argmax front to the span back
    typedef struct packed {
        logic [IDX_W-1:0]   best_index;
        logic signed [15:0] best_score;
        logic               eos;
    } t_frame_rec;

endpackage

// ===== rtl/core/ctcgsd_front.sv =====
module ctcgsd_front #(
    parameter int unsigned MAX_VOCAB = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  ctcgsd_pkg::t_in_item   i_item,
    input  logic [12:0]            i_vocab_size,
    input  logic                   i_full,
    output logic                   o_push,
    output ctcgsd_pkg::t_frame_rec o_rec
);
    import ctcgsd_pkg::*;

    localparam int unsigned EW = $clog2(MAX_VOCAB);
    localparam int unsigned VW = $clog2(MAX_VOCAB + 1);

    logic [EW-1:0]      r_elem;
    logic signed [15:0] r_best_score;
    logic [EW-1:0]      r_best_idx;

    logic [VW-1:0]      vs_eff;
    logic               accept;
    logic               take;
    logic               frame_end;
    logic signed [15:0] n_best_score;
    logic [EW-1:0]      n_best_idx;

    always_comb begin
        // zero counts as one score per frame, oversize saturates
        if (i_vocab_size == 13'd0) begin
            vs_eff = VW'(1);
        end else if (32'(i_vocab_size) > MAX_VOCAB) begin
            vs_eff = VW'(MAX_VOCAB);
        end else begin
            vs_eff = VW'(i_vocab_size);
        end
        accept       = i_valid && !i_full;
        take         = (r_elem == '0) || (i_item.score > r_best_score);
        n_best_score = take ? i_item.score : r_best_score;
        n_best_idx   = take ? r_elem : r_best_idx;
        frame_end    = (32'(r_elem) + 32'd1) >= 32'(vs_eff);
    end

    assign o_stall = i_full;
    assign o_push  = accept && frame_end;
    assign o_rec   = '{best_index: IDX_W'(n_best_idx),
                       best_score: n_best_score,
                       eos:        i_item.end_of_sequence};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem       <= '0;
            r_best_score <= '0;
            r_best_idx   <= '0;
        end else if (accept) begin
            r_best_score <= n_best_score;
            r_best_idx   <= n_best_idx;
            r_elem       <= frame_end ? '0 : r_elem + 1'b1;
        end
    end

endmodule

// ===== rtl/core/ctcgsd_queue.sv =====
module ctcgsd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ctcgsd_pkg::t_frame_rec i_rec,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_not_empty,
    output ctcgsd_pkg::t_frame_rec o_rec
);
    import ctcgsd_pkg::*;

    t_frame_rec        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_full      = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_rec       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ===== rtl/core/ctcgsd_back.sv =====
module ctcgsd_back #(
    parameter int unsigned MAX_FRAMES = 65536
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_not_empty,
    input  ctcgsd_pkg::t_frame_rec i_rec,
    output logic                   o_pop,
    input  logic [11:0]            i_blank_id,
    output logic                   o_valid,
    input  logic                   i_stall,
    output ctcgsd_pkg::t_out_item  o_item
);
    import ctcgsd_pkg::*;

    localparam int unsigned FW = $clog2(MAX_FRAMES);

    logic [FW-1:0]      r_t;
    logic [IDX_W-1:0]   r_prev_sym;
    logic               r_prev_valid;
    logic [IDX_W-1:0]   r_open_tok;
    logic [FW-1:0]      r_open_start;
    logic signed [15:0] r_open_score;
    logic               r_span_open;
    logic               r_ov;
    t_out_item          r_out;
    logic               r_pv;
    t_out_item          r_pend;

    logic               out_free;
    logic               change;
    logic               is_blank;
    logic               close;
    logic               n_open;
    logic [IDX_W-1:0]   n_tok;
    logic [FW-1:0]      n_start;
    logic signed [15:0] n_score;
    logic [FW-1:0]      t_next;
    logic [FW-1:0]      t_prev;
    t_out_item          res_close;
    t_out_item          res_eos;

    always_comb begin
        out_free = !r_ov || !i_stall;
        change   = !(r_prev_valid && (i_rec.best_index == r_prev_sym));
        is_blank = i_rec.best_index == IDX_W'(i_blank_id);
        close    = change && r_span_open;
        n_open   = change ? !is_blank : r_span_open;
        if (change && !is_blank) begin
            n_tok   = i_rec.best_index;
            n_start = r_t;
            n_score = i_rec.best_score;
        end else begin
            n_tok   = r_open_tok;
            n_start = r_open_start;
            n_score = r_open_score;
        end
        t_next = (r_t == FW'(MAX_FRAMES - 1)) ? '0 : r_t + 1'b1;
        t_prev = (r_t == '0) ? FW'(MAX_FRAMES - 1) : r_t - 1'b1;

        res_close = '{token_id:      12'(r_open_tok),
                      start_frame:   16'(r_open_start),
                      stop_frame:    16'(t_prev),
                      span_score:    r_open_score,
                      has_token:     1'b1,
                      sequence_done: 1'b0,
                      last:          !i_rec.eos};
        if (n_open) begin
            res_eos = '{token_id:      12'(n_tok),
                        start_frame:   16'(n_start),
                        stop_frame:    16'(r_t),
                        span_score:    n_score,
                        has_token:     1'b1,
                        sequence_done: 1'b1,
                        last:          1'b1};
        end else begin
            res_eos               = '0;
            res_eos.sequence_done = 1'b1;
            res_eos.last          = 1'b1;
        end
    end

    // a second result waits in the pending slot and blocks further pops
    assign o_pop   = out_free && !r_pv && i_not_empty;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t          <= '0;
            r_prev_sym   <= '0;
            r_prev_valid <= 1'b0;
            r_open_tok   <= '0;
            r_open_start <= '0;
            r_open_score <= '0;
            r_span_open  <= 1'b0;
            r_ov         <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            if (out_free && r_pv) begin
                r_out <= r_pend;
                r_ov  <= 1'b1;
                r_pv  <= 1'b0;
            end else if (o_pop) begin
                r_ov <= i_rec.eos || close;
                if (i_rec.eos) begin
                    if (close) begin
                        r_out  <= res_close;
                        r_pend <= res_eos;
                        r_pv   <= 1'b1;
                    end else begin
                        r_out <= res_eos;
                    end
                    r_t          <= '0;
                    r_prev_sym   <= '0;
                    r_prev_valid <= 1'b0;
                    r_open_tok   <= '0;
                    r_open_start <= '0;
                    r_open_score <= '0;
                    r_span_open  <= 1'b0;
                end else begin
                    if (close) begin
                        r_out <= res_close;
                    end
                    r_t          <= t_next;
                    r_prev_sym   <= i_rec.best_index;
                    r_prev_valid <= 1'b1;
                    r_open_tok   <= n_tok;
                    r_open_start <= n_start;
                    r_open_score <= n_score;
                    r_span_open  <= n_open;
                end
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
        end
    end

    a_pend_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> r_ov)
        else $error("pending result without a result in the output register");

    a_pend_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_pend.sequence_done && r_pend.last))
        else $error("pending result is not the sequence end");

    a_marker_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_out.has_token) |-> (r_out.sequence_done && r_out.last))
        else $error("empty marker that does not end the sequence");

endmodule

// ===== rtl/core/ctc_greedy_span_decoder.sv =====
// a frame's first result passes the frame queue and is then registered at the output;
// a second result (span close plus sequence end) waits in the pending slot behind it
// throughput: one score per cycle; the argmax front and the span back are split by a
// four-entry frame queue, so the input only stalls when that queue fills
// reset: synchronous active low; counters, span state and queue clear, registers reload
module ctc_greedy_span_decoder #(
    parameter int unsigned MAX_VOCAB  = 4096,
    parameter int unsigned MAX_FRAMES = 65536
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ctcgsd_pkg::t_in_item  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ctcgsd_pkg::t_out_item o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import ctcgsd_pkg::*;

    logic [12:0] r_vocab_size;
    logic [11:0] r_blank_id;
    logic        wr_en;
    logic        reg_sel;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    t_frame_rec  rec_in;
    t_frame_rec  rec_out;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab_size <= 13'(VOCAB_RESET);
            r_blank_id   <= 12'(BLANK_RESET);
        end else if (wr_en) begin
            if (reg_sel == 1'(REG_VOCAB_SIZE)) begin
                r_vocab_size <= pwdata[12:0];
            end else begin
                r_blank_id <= pwdata[11:0];
            end
        end
    end

    always_comb begin
        // unaligned reads return zero
        if (paddr[1:0] != 2'b00) begin
            prdata = '0;
        end else if (reg_sel == 1'(REG_VOCAB_SIZE)) begin
            prdata = 32'(r_vocab_size);
        end else begin
            prdata = 32'(r_blank_id);
        end
    end

    ctcgsd_front #(
        .MAX_VOCAB(MAX_VOCAB)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_item      (i_in_data),
        .i_vocab_size(r_vocab_size),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_rec       (rec_in)
    );

    ctcgsd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_rec      (rec_in),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_not_empty(q_not_empty),
        .o_rec      (rec_out)
    );

    ctcgsd_back #(
        .MAX_FRAMES(MAX_FRAMES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_not_empty(q_not_empty),
        .i_rec      (rec_out),
        .o_pop      (q_pop),
        .i_blank_id (r_blank_id),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_item     (o_out_data)
    );

endmodule
